// ===== src/assert_macros.svh =====
// Assertion helpers for the frame receiver checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, masked during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== src/crcfr_pkg.sv =====
package crcfr_pkg;

   localparam int PAYLOAD_MAX_DEF = 1024;
   localparam int ARGS_MAX_DEF    = 512;
   localparam int HDR_BYTES       = 4;
   localparam int CMP_W           = 17;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_TOP  = 16'h8000;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_FIRST   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_SECOND  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COMMAND_TYPE = 2'd2;

   localparam logic [7:0] SYNC_FIRST_RST   = 8'hAA;
   localparam logic [7:0] SYNC_SECOND_RST  = 8'h55;
   localparam logic [7:0] COMMAND_TYPE_RST = 8'h01;

   typedef enum logic [1:0] {
      OP_RX      = 2'd0,
      OP_READ    = 2'd1,
      OP_RELEASE = 2'd2,
      OP_NOP     = 2'd3
   } op_type;

   // Frame-end report from the parser.
   typedef struct packed {
      logic done;
      logic good;
      logic cmd_ok;
   } frame_evt_type;

   // CRC-16/CCITT, MSB first, one byte.
   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_TOP) != 16'h0000) begin
            c = (c << 1) ^ CRC_POLY;
         end else begin
            c = c << 1;
         end
      end
      return c;
   endfunction

endpackage

// ===== src/crcfr_ram.sv =====
module crcfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/crcfr_parser.sv =====
module crcfr_parser #(
   parameter int PAYLOAD_MAX = crcfr_pkg::PAYLOAD_MAX_DEF,
   parameter int ARGS_MAX    = crcfr_pkg::ARGS_MAX_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               byte_valid,
   input  logic [7:0]                         rx_byte,
   input  logic [7:0]                         sync_first,
   input  logic [7:0]                         sync_second,
   input  logic [7:0]                         command_type,
   output logic                               wr_en,
   output logic [$clog2(PAYLOAD_MAX)-1:0]     wr_addr,
   output crcfr_pkg::frame_evt_type           evt,
   output logic [7:0]                         hdr_id,
   output logic [7:0]                         hdr_seq,
   output logic [$clog2(ARGS_MAX+1)-1:0]      hdr_alen
);

   import crcfr_pkg::*;

   localparam int LEN_W  = $clog2(PAYLOAD_MAX + 1);
   localparam int ADDR_W = $clog2(PAYLOAD_MAX);
   localparam int ALEN_W = $clog2(ARGS_MAX + 1);

   typedef enum logic [2:0] {
      PH_SYNC1   = 3'd0,
      PH_SYNC2   = 3'd1,
      PH_TYPE    = 3'd2,
      PH_LENLO   = 3'd3,
      PH_LENHI   = 3'd4,
      PH_PAYLOAD = 3'd5,
      PH_CRC     = 3'd6
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [7:0]        type_ff, type_in;
   logic [7:0]        lenlo_ff, lenlo_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  count_ff, count_in;
   logic [15:0]       crc_ff, crc_in;
   logic [7:0]        crclo_ff, crclo_in;
   logic              crccnt_ff, crccnt_in;
   logic [7:0]        id_ff, id_in;
   logic [7:0]        seq_ff, seq_in;
   logic [7:0]        alo_ff, alo_in;
   logic [7:0]        ahi_ff, ahi_in;

   logic [15:0]       crc_next;
   logic [15:0]       len_full;
   logic [LEN_W-1:0]  count_inc;
   logic [15:0]       alen_full;
   logic [CMP_W-1:0]  alen_plus;
   logic [CMP_W-1:0]  len_cmp;

   assign crc_next  = crc_step(crc_ff, rx_byte);
   assign len_full  = {rx_byte, lenlo_ff};
   assign count_inc = count_ff + LEN_W'(1);
   assign alen_full = {ahi_ff, alo_ff};
   assign alen_plus = CMP_W'(alen_full) + CMP_W'(HDR_BYTES);
   assign len_cmp   = CMP_W'(len_ff);

   always_comb begin
      phase_in  = phase_ff;
      type_in   = type_ff;
      lenlo_in  = lenlo_ff;
      len_in    = len_ff;
      count_in  = count_ff;
      crc_in    = crc_ff;
      crclo_in  = crclo_ff;
      crccnt_in = crccnt_ff;
      id_in     = id_ff;
      seq_in    = seq_ff;
      alo_in    = alo_ff;
      ahi_in    = ahi_ff;
      wr_en     = 1'b0;
      evt       = '0;
      if (byte_valid) begin
         unique case (phase_ff)
            PH_SYNC1: begin
               if (rx_byte == sync_first) begin
                  phase_in = PH_SYNC2;
               end
            end
            PH_SYNC2: begin
               if (rx_byte == sync_second) begin
                  phase_in = PH_TYPE;
                  crc_in   = CRC_INIT;
               end else begin
                  phase_in = PH_SYNC1;
               end
            end
            PH_TYPE: begin
               type_in  = rx_byte;
               crc_in   = crc_next;
               phase_in = PH_LENLO;
            end
            PH_LENLO: begin
               lenlo_in = rx_byte;
               crc_in   = crc_next;
               phase_in = PH_LENHI;
            end
            PH_LENHI: begin
               crc_in    = crc_next;
               count_in  = '0;
               crccnt_in = 1'b0;
               if (CMP_W'(len_full) > CMP_W'(PAYLOAD_MAX)) begin
                  phase_in = PH_SYNC1;
                  len_in   = '0;
               end else begin
                  len_in   = len_full[LEN_W-1:0];
                  phase_in = (len_full != 16'h0000) ? PH_PAYLOAD : PH_CRC;
               end
            end
            PH_PAYLOAD: begin
               wr_en    = 1'b1;
               crc_in   = crc_next;
               count_in = count_inc;
               // first four payload bytes form the command header
               if (count_ff == LEN_W'(0)) id_in  = rx_byte;
               if (count_ff == LEN_W'(1)) seq_in = rx_byte;
               if (count_ff == LEN_W'(2)) alo_in = rx_byte;
               if (count_ff == LEN_W'(3)) ahi_in = rx_byte;
               if (count_inc >= len_ff) begin
                  phase_in  = PH_CRC;
                  crccnt_in = 1'b0;
               end
            end
            PH_CRC: begin
               if (!crccnt_ff) begin
                  crclo_in  = rx_byte;
                  crccnt_in = 1'b1;
               end else begin
                  evt.done   = 1'b1;
                  evt.good   = ({rx_byte, crclo_ff} == crc_ff);
                  evt.cmd_ok = evt.good && (type_ff == command_type)
                               && (len_cmp >= CMP_W'(HDR_BYTES))
                               && (alen_plus == len_cmp)
                               && (CMP_W'(alen_full) <= CMP_W'(ARGS_MAX));
                  phase_in  = PH_SYNC1;
                  len_in    = '0;
                  count_in  = '0;
                  crccnt_in = 1'b0;
               end
            end
            default: begin
               phase_in  = PH_SYNC1;
               len_in    = '0;
               count_in  = '0;
               crccnt_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SYNC1;
         type_ff   <= '0;
         lenlo_ff  <= '0;
         len_ff    <= '0;
         count_ff  <= '0;
         crc_ff    <= CRC_INIT;
         crclo_ff  <= '0;
         crccnt_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         type_ff   <= type_in;
         lenlo_ff  <= lenlo_in;
         len_ff    <= len_in;
         count_ff  <= count_in;
         crc_ff    <= crc_in;
         crclo_ff  <= crclo_in;
         crccnt_ff <= crccnt_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff  <= id_in;
      seq_ff <= seq_in;
      alo_ff <= alo_in;
      ahi_ff <= ahi_in;
   end

   assign wr_addr  = count_ff[ADDR_W-1:0];
   assign hdr_id   = id_ff;
   assign hdr_seq  = seq_ff;
   assign hdr_alen = alen_full[ALEN_W-1:0];

endmodule

// ===== src/crc_frame_command_receiver.sv =====
// Channel   Ports                         Direction  Meaning
// req       req_valid / req_stall         in         one op word: rx byte, arg read, release, nop
// rsp       rsp_valid / rsp_stall         out        one result word per accepted req word
// csr       csr_write / csr_index / data  in         sync bytes and command type
//
// One req word is taken every cycle while req_stall is low; its rsp word appears in the next cycle,
// set by the output register and the registered read port of the payload memory.
// The parser state and slot registers update at acceptance, so the next
// word may follow at once.
// Reset is synchronous; the memory needs no clearing pass.
// req_stall follows rsp_stall while a rsp word is held.
module crc_frame_command_receiver #(
   parameter int PAYLOAD_MAX = crcfr_pkg::PAYLOAD_MAX_DEF,
   parameter int ARGS_MAX    = crcfr_pkg::ARGS_MAX_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_op,
   input  logic [7:0]                        req_rx_byte,
   input  logic [$clog2(ARGS_MAX)-1:0]       req_arg_index,
   input  logic [$clog2(ARGS_MAX+1)-1:0]     req_arg_capacity,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_frame_done,
   output logic                              rsp_crc_good,
   output logic                              rsp_command_stored,
   output logic                              rsp_command_waiting,
   output logic [7:0]                        rsp_command_id,
   output logic [7:0]                        rsp_command_seq,
   output logic [$clog2(ARGS_MAX+1)-1:0]     rsp_argument_length,
   output logic [7:0]                        rsp_argument_byte,
   output logic                              rsp_release_ok,
   input  logic                              csr_write,
   input  logic [crcfr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [7:0]                        csr_wdata
);

   import crcfr_pkg::*;

   localparam int ADDR_W = $clog2(PAYLOAD_MAX);
   localparam int ALEN_W = $clog2(ARGS_MAX + 1);
   // two banks: the parser fills one while the slot owns the other
   localparam int MEM_DEPTH = 2 * (1 << ADDR_W);

   // config registers
   logic [7:0] sync_first_ff, sync_second_ff, command_type_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff   <= SYNC_FIRST_RST;
         sync_second_ff  <= SYNC_SECOND_RST;
         command_type_ff <= COMMAND_TYPE_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SYNC_FIRST:   sync_first_ff   <= csr_wdata;
            CSR_SYNC_SECOND:  sync_second_ff  <= csr_wdata;
            CSR_COMMAND_TYPE: command_type_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // handshake: the output register is the only pipeline stage
   logic   advance;
   logic   accept;
   op_type op;

   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;
   assign accept    = req_valid && advance;
   assign op        = op_type'(req_op);

   // frame parser
   logic                  p_wr_en;
   logic [ADDR_W-1:0]     p_wr_addr;
   frame_evt_type         p_evt;
   logic [7:0]            p_id, p_seq;
   logic [ALEN_W-1:0]     p_alen;

   crcfr_parser #(
      .PAYLOAD_MAX (PAYLOAD_MAX),
      .ARGS_MAX    (ARGS_MAX)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .byte_valid   (accept && (op == OP_RX)),
      .rx_byte      (req_rx_byte),
      .sync_first   (sync_first_ff),
      .sync_second  (sync_second_ff),
      .command_type (command_type_ff),
      .wr_en        (p_wr_en),
      .wr_addr      (p_wr_addr),
      .evt          (p_evt),
      .hdr_id       (p_id),
      .hdr_seq      (p_seq),
      .hdr_alen     (p_alen)
   );

   // command slot; its arguments stay in the bank it was parsed into
   logic              slot_full_ff, slot_full_in;
   logic              slot_bank_ff, slot_bank_in;
   logic [7:0]        slot_id_ff, slot_id_in;
   logic [7:0]        slot_seq_ff, slot_seq_in;
   logic [ALEN_W-1:0] slot_len_ff, slot_len_in;
   logic              stored, released, arg_hit;
   logic [ALEN_W-1:0] cap_eff;
   logic [CMP_W-1:0]  arg_ofs;

   always_comb begin
      slot_full_in = slot_full_ff;
      slot_bank_in = slot_bank_ff;
      slot_id_in   = slot_id_ff;
      slot_seq_in  = slot_seq_ff;
      slot_len_in  = slot_len_ff;
      stored       = 1'b0;
      released     = 1'b0;
      arg_hit      = 1'b0;
      // capacity above the argument limit counts as the limit
      cap_eff = (CMP_W'(req_arg_capacity) > CMP_W'(ARGS_MAX)) ?
                ALEN_W'(ARGS_MAX) : req_arg_capacity;
      if (accept) begin
         unique case (op)
            OP_RX: begin
               if (p_evt.done && p_evt.cmd_ok && !slot_full_ff) begin
                  stored       = 1'b1;
                  slot_full_in = 1'b1;
                  slot_bank_in = !slot_bank_ff;
                  slot_id_in   = p_id;
                  slot_seq_in  = p_seq;
                  slot_len_in  = p_alen;
               end
            end
            OP_READ: begin
               arg_hit = slot_full_ff
                         && (ALEN_W'(req_arg_index) < slot_len_ff)
                         && (CMP_W'(req_arg_index) < CMP_W'(ARGS_MAX));
            end
            OP_RELEASE: begin
               if (slot_full_ff && (slot_len_ff <= cap_eff)) begin
                  released     = 1'b1;
                  slot_full_in = 1'b0;
               end
            end
            OP_NOP: ;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_full_ff <= 1'b0;
         slot_bank_ff <= 1'b0;
         slot_id_ff   <= '0;
         slot_seq_ff  <= '0;
         slot_len_ff  <= '0;
      end else begin
         slot_full_ff <= slot_full_in;
         slot_bank_ff <= slot_bank_in;
         slot_id_ff   <= slot_id_in;
         slot_seq_ff  <= slot_seq_in;
         slot_len_ff  <= slot_len_in;
      end
   end

   // payload memory: writes go to the free bank, reads to the slot bank,
   // so the two ports never touch the same entry
   logic [7:0] rd_data;

   assign arg_ofs = CMP_W'(req_arg_index) + CMP_W'(HDR_BYTES);

   crcfr_ram #(
      .WIDTH (8),
      .DEPTH (MEM_DEPTH)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (p_wr_en),
      .wr_addr ({!slot_bank_ff, p_wr_addr}),
      .wr_data (req_rx_byte),
      .rd_en   (advance),
      .rd_addr ({slot_bank_ff, arg_ofs[ADDR_W-1:0]}),
      .rd_data (rd_data)
   );

   // output register
   logic              rsp_valid_ff;
   logic              done_ff, good_ff, stored_ff, waiting_ff, hit_ff, rel_ff;
   logic [7:0]        id_ff, seq_ff;
   logic [ALEN_W-1:0] len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         done_ff    <= p_evt.done && (op == OP_RX);
         good_ff    <= p_evt.good && (op == OP_RX);
         stored_ff  <= stored;
         waiting_ff <= slot_full_in;
         id_ff      <= slot_full_in ? slot_id_in  : 8'h00;
         seq_ff     <= slot_full_in ? slot_seq_in : 8'h00;
         len_ff     <= slot_full_in ? slot_len_in : '0;
         hit_ff     <= arg_hit;
         rel_ff     <= released;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_frame_done      = done_ff;
   assign rsp_crc_good        = good_ff;
   assign rsp_command_stored  = stored_ff;
   assign rsp_command_waiting = waiting_ff;
   assign rsp_command_id      = id_ff;
   assign rsp_command_seq     = seq_ff;
   assign rsp_argument_length = len_ff;
   assign rsp_argument_byte   = hit_ff ? rd_data : 8'h00;
   assign rsp_release_ok      = rel_ff;

endmodule

// ===== src/crcfr_checker.sv =====
`include "assert_macros.svh"

module crcfr_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_frame_done,
   input logic rsp_crc_good,
   input logic rsp_command_stored,
   input logic rsp_command_waiting,
   input logic rsp_release_ok
);

   // a held word stays offered
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // a good CRC is only reported at a frame end
   `ASSERT_IMPLY(a_good_done, clock, reset, rsp_valid && rsp_crc_good, rsp_frame_done)

   // a stored command is a good frame and leaves the slot full
   `ASSERT_IMPLY(a_store_full, clock, reset, rsp_valid && rsp_command_stored,
                 rsp_crc_good && rsp_command_waiting)

   // a release empties the slot and is not reported as a frame end
   `ASSERT_IMPLY(a_release_empty, clock, reset, rsp_valid && rsp_release_ok,
                 !rsp_command_waiting && !rsp_frame_done)

endmodule

bind crc_frame_command_receiver crcfr_checker u_crcfr_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_frame_done      (rsp_frame_done),
   .rsp_crc_good        (rsp_crc_good),
   .rsp_command_stored  (rsp_command_stored),
   .rsp_command_waiting (rsp_command_waiting),
   .rsp_release_ok      (rsp_release_ok)
);
